// ===== rtl/ppfe_pkg.sv =====
// Shared types and constants of the potential-particle field evaluator.
`timescale 1ns / 1ps
package ppfe_pkg;

    // Input item and result item carried on the streaming channels
    typedef struct packed {
        logic        [1:0]  operation;
        logic        [3:0]  slot;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] potential;
        logic               saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD_PLANE  = 2'd0,
        OP_LOAD_ROW    = 2'd1,
        OP_LOAD_CENTRE = 2'd2,
        OP_EVAL        = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_BLEND_WEIGHT = 3'd0,
        CFG_INV_INNER    = 3'd1,
        CFG_INV_OUTER    = 3'd2,
        CFG_PLANE_COUNT  = 3'd3,
        CFG_CENTRE_MODE  = 3'd4
    } cfg_idx_t;

    // Operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ROT,
        MUL_PX,
        MUL_PY,
        MUL_PZ,
        MUL_SQ,
        MUL_SPH,
        MUL_T1H,
        MUL_T1L,
        MUL_T2H,
        MUL_T2L,
        MUL_B1H,
        MUL_B1L,
        MUL_B2H,
        MUL_B2L
    } mul_sel_t;

    // What to do with a product in the cycle after it was issued
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ADD,
        ACT_LOAD_HI,
        ACT_ADD_HI,
        ACT_ROW_END,
        ACT_LOC_SUB,
        ACT_DIST,
        ACT_SQ,
        ACT_SPH,
        ACT_TERM1,
        ACT_TERM2,
        ACT_FINAL
    } act_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        act_t       act;
        logic [1:0] row;
        logic [1:0] col;
        logic       publish;
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0] plane_count;
        logic       centre_mode;
    } dp_status_t;

    localparam logic [16:0]        ONE_Q16  = 17'd65536;
    localparam logic signed [31:0] Q16_ONE_S = 32'sd65536;
    localparam logic signed [67:0] TERM_CAP = 68'sh0_0000_FFFF_FFFF_FFFF;
    localparam logic signed [67:0] OUT_MAX  = 68'sh0_0000_7FFF_FFFF_FFFF;
    localparam logic signed [67:0] HALF_LSB = 68'sd32768;

endpackage

// ===== rtl/ppfe_stream_if.sv =====
// Valid/ready streaming channel with a typed payload.
`timescale 1ns / 1ps
interface ppfe_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ppfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ppfe_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/ppfe_ctrl.sv =====
// Sequencer for the evaluator: walks the multiplier schedule of one point.
`timescale 1ns / 1ps
module ppfe_ctrl #(
    parameter int MAX_PLANES = 16,
    parameter int AW         = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [1:0]          item_op,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  ppfe_pkg::dp_status_t status,
    output ppfe_pkg::dp_cmd_t    cmd,
    output logic [AW-1:0]       plane_addr
);
    import ppfe_pkg::*;

    localparam int PCW = $clog2(MAX_PLANES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LOCSUB, S_ROT, S_LEAD,
        S_PX, S_PY, S_PZ, S_PGAP, S_PSQ,
        S_SPH, S_T1H, S_T1L, S_T2H, S_T2L,
        S_B1H, S_B1L, S_B2H, S_B2L, S_DRAIN, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       row_reg, row_next;
    logic [1:0]       col_reg, col_next;
    logic [PCW-1:0]   pidx_reg, pidx_next;
    logic             out_valid_reg, out_valid_next;
    logic [PCW-1:0]   n_eff;
    logic             item_xfer;
    logic             publish;

    // Clip the plane count to the table size
    always_comb
    begin
        if (32'(status.plane_count) > MAX_PLANES)
        begin
            n_eff = PCW'(MAX_PLANES);
        end
        else
        begin
            n_eff = PCW'(status.plane_count);
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign publish    = (state_reg == S_DONE) && (!out_valid_reg || result_ready);

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pidx_next  = pidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                row_next  = 2'd0;
                col_next  = 2'd0;
                pidx_next = '0;
                if (item_xfer && (item_op == OP_EVAL))
                begin
                    state_next = status.centre_mode ? S_LOCSUB : S_ROT;
                end
            end
            S_LOCSUB: state_next = S_LEAD;
            S_ROT:
            begin
                if (col_reg == 2'd2)
                begin
                    col_next = 2'd0;
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd2)
                    begin
                        state_next = S_LEAD;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            S_LEAD:   state_next = (n_eff == '0) ? S_SPH : S_PX;
            S_PX:     state_next = S_PY;
            S_PY:     state_next = S_PZ;
            S_PZ:     state_next = S_PGAP;
            S_PGAP:
            begin
                pidx_next  = pidx_reg + PCW'(1);
                state_next = S_PSQ;
            end
            S_PSQ:    state_next = (pidx_reg == n_eff) ? S_SPH : S_PX;
            S_SPH:
            begin
                if (col_reg == 2'd2)
                begin
                    col_next   = 2'd0;
                    state_next = S_T1H;
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            S_T1H:    state_next = S_T1L;
            S_T1L:    state_next = S_T2H;
            S_T2H:    state_next = S_T2L;
            S_T2L:    state_next = S_B1H;
            S_B1H:    state_next = S_B1L;
            S_B1L:    state_next = S_B2H;
            S_B2H:    state_next = S_B2L;
            S_B2L:    state_next = S_DRAIN;
            S_DRAIN:  state_next = S_DONE;
            S_DONE:   state_next = publish ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until the sink takes the transfer
    always_comb
    begin
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 2'd0;
            col_reg       <= 2'd0;
            pidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pidx_reg      <= pidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    // Plane table address: fetch the next plane early, from the gap state
    always_comb
    begin
        if (state_reg == S_PGAP)
        begin
            plane_addr = AW'(pidx_reg + PCW'(1));
        end
        else
        begin
            plane_addr = pidx_reg[AW-1:0];
        end
    end

    // Datapath commands per state
    always_comb
    begin
        cmd.mul_sel = MUL_NONE;
        cmd.act     = ACT_NONE;
        cmd.row     = row_reg;
        cmd.col     = col_reg;
        cmd.publish = publish;
        unique case (state_reg)
            S_LOCSUB: cmd.act = ACT_LOC_SUB;
            S_ROT:
            begin
                cmd.mul_sel = MUL_ROT;
                if (col_reg == 2'd2)
                begin
                    cmd.act = ACT_ROW_END;
                end
                else if (col_reg == 2'd0)
                begin
                    cmd.act = ACT_LOAD;
                end
                else
                begin
                    cmd.act = ACT_ADD;
                end
            end
            S_PX:
            begin
                cmd.mul_sel = MUL_PX;
                cmd.act     = ACT_LOAD;
            end
            S_PY:
            begin
                cmd.mul_sel = MUL_PY;
                cmd.act     = ACT_ADD;
            end
            S_PZ:
            begin
                cmd.mul_sel = MUL_PZ;
                cmd.act     = ACT_DIST;
            end
            S_PSQ:
            begin
                cmd.mul_sel = MUL_SQ;
                cmd.act     = ACT_SQ;
            end
            S_SPH:
            begin
                cmd.mul_sel = MUL_SPH;
                if (col_reg == 2'd2)
                begin
                    cmd.act = ACT_SPH;
                end
                else if (col_reg == 2'd0)
                begin
                    cmd.act = ACT_LOAD;
                end
                else
                begin
                    cmd.act = ACT_ADD;
                end
            end
            S_T1H:
            begin
                cmd.mul_sel = MUL_T1H;
                cmd.act     = ACT_LOAD;
            end
            S_T1L:
            begin
                cmd.mul_sel = MUL_T1L;
                cmd.act     = ACT_TERM1;
            end
            S_T2H:
            begin
                cmd.mul_sel = MUL_T2H;
                cmd.act     = ACT_LOAD;
            end
            S_T2L:
            begin
                cmd.mul_sel = MUL_T2L;
                cmd.act     = ACT_TERM2;
            end
            S_B1H:
            begin
                cmd.mul_sel = MUL_B1H;
                cmd.act     = ACT_LOAD_HI;
            end
            S_B1L:
            begin
                cmd.mul_sel = MUL_B1L;
                cmd.act     = ACT_ADD;
            end
            S_B2H:
            begin
                cmd.mul_sel = MUL_B2H;
                cmd.act     = ACT_ADD_HI;
            end
            S_B2L:
            begin
                cmd.mul_sel = MUL_B2L;
                cmd.act     = ACT_FINAL;
            end
            default:
            begin
                cmd.mul_sel = MUL_NONE;
                cmd.act     = ACT_NONE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted point starts a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item_op == OP_EVAL)) |=> (state_reg != S_IDLE))
        else $error("evaluate transfer did not start the sequencer");

    // The plane counter never passes the planes in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PSQ) |-> ((pidx_reg <= n_eff) && (pidx_reg != '0)))
        else $error("plane counter out of range");

    // A finished result is shown on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        publish |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not presented after publish");

    // No new item while a point is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !item_ready)
        else $error("item accepted during evaluation");
`endif
endmodule

// ===== rtl/ppfe_datapath.sv =====
// Datapath: tables, configuration, shared multiplier and accumulator.
`timescale 1ns / 1ps
module ppfe_datapath #(
    parameter int MAX_PLANES = 16,
    parameter int AW         = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_xfer,
    input  ppfe_pkg::in_item_t   item_data,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  ppfe_pkg::dp_cmd_t    cmd,
    input  logic [AW-1:0]        plane_addr,
    output ppfe_pkg::dp_status_t status,
    output ppfe_pkg::out_item_t  result_data
);
    import ppfe_pkg::*;

    localparam int PSUM_W = 48 + $clog2(MAX_PLANES + 1);

    // Configuration
    logic [16:0]        blend_reg;
    logic [31:0]        inv_in_reg;
    logic [31:0]        inv_out_reg;
    logic [4:0]         pcount_reg;
    logic               cmode_reg;

    // Loaded state and point
    logic signed [31:0] rot_reg [3][3];
    logic signed [31:0] centre_reg [3];
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] loc_reg [3];
    logic signed [31:0] loc_next [3];

    // Working registers
    logic [31:0]        du_reg, du_next;
    logic [PSUM_W-1:0]  psum_reg, psum_next;
    logic [47:0]        pcap_reg;
    logic [47:0]        sph_reg, sph_next;
    logic [47:0]        t1_reg, t1_next;
    logic [47:0]        t2_reg, t2_next;
    logic [16:0]        kc_reg;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [67:0] acc_reg, acc_next;
    act_t               act_reg;
    logic [1:0]         row_d_reg;
    logic [47:0]        f_reg, f_next;
    logic               fsat_reg, fsat_next;
    out_item_t          out_reg;

    logic               plane_we;
    logic [127:0]       plane_rd;
    logic signed [31:0] pnx, pny, pnz, poff;
    logic signed [32:0] op_a, op_b;
    logic [16:0]        omk;
    logic signed [67:0] prod_ext, sum_w, rnd_w, prnd_w, tsum_w, dv_w, fr_w;
    logic [65:0]        sqr_w;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -68'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Plane table
    assign plane_we = item_xfer && (item_data.operation == OP_LOAD_PLANE)
                      && (32'(item_data.slot) < MAX_PLANES);

    ppfe_ram #(
        .WIDTH (128),
        .DEPTH (MAX_PLANES),
        .AW    (AW)
    ) u_plane_ram (
        .clk   (clk),
        .we    (plane_we),
        .waddr (AW'(item_data.slot)),
        .wdata ({item_data.value_d, item_data.value_c,
                 item_data.value_b, item_data.value_a}),
        .raddr (plane_addr),
        .rdata (plane_rd)
    );

    assign pnx  = plane_rd[31:0];
    assign pny  = plane_rd[63:32];
    assign pnz  = plane_rd[95:64];
    assign poff = plane_rd[127:96];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg   <= 17'd0;
            inv_in_reg  <= 32'(ONE_Q16);
            inv_out_reg <= 32'(ONE_Q16);
            pcount_reg  <= 5'd0;
            cmode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BLEND_WEIGHT: blend_reg   <= cfg_data[16:0];
                CFG_INV_INNER:    inv_in_reg  <= cfg_data;
                CFG_INV_OUTER:    inv_out_reg <= cfg_data;
                CFG_PLANE_COUNT:  pcount_reg  <= cfg_data[4:0];
                CFG_CENTRE_MODE:  cmode_reg   <= cfg_data[0];
                default:          cmode_reg   <= cmode_reg;
            endcase
        end
    end

    assign status.plane_count = pcount_reg;
    assign status.centre_mode = cmode_reg;

    // Rotation rows and centre loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rot_reg[r][c] <= (r == c) ? Q16_ONE_S : 32'sd0;
                end
                centre_reg[r] <= 32'sd0;
            end
        end
        else if (item_xfer)
        begin
            if ((item_data.operation == OP_LOAD_ROW) && (item_data.slot < 4'd3))
            begin
                rot_reg[item_data.slot[1:0]][0] <= item_data.value_a;
                rot_reg[item_data.slot[1:0]][1] <= item_data.value_b;
                rot_reg[item_data.slot[1:0]][2] <= item_data.value_c;
            end
            if (item_data.operation == OP_LOAD_CENTRE)
            begin
                centre_reg[0] <= item_data.value_a;
                centre_reg[1] <= item_data.value_b;
                centre_reg[2] <= item_data.value_c;
            end
        end
    end

    // Capture the point of an evaluate transfer
    always_ff @(posedge clk)
    begin
        if (item_xfer && (item_data.operation == OP_EVAL))
        begin
            pt_reg[0] <= item_data.value_a;
            pt_reg[1] <= item_data.value_b;
            pt_reg[2] <= item_data.value_c;
        end
    end

    // Multiplier operand select
    assign omk = ONE_Q16 - kc_reg;

    always_comb
    begin
        op_a = 33'sd0;
        op_b = 33'sd0;
        case (cmd.mul_sel)
            MUL_ROT:
            begin
                op_a = {rot_reg[cmd.row][cmd.col][31], rot_reg[cmd.row][cmd.col]};
                op_b = {pt_reg[cmd.col][31], pt_reg[cmd.col]};
            end
            MUL_PX:
            begin
                op_a = {pnx[31], pnx};
                op_b = {loc_reg[0][31], loc_reg[0]};
            end
            MUL_PY:
            begin
                op_a = {pny[31], pny};
                op_b = {loc_reg[1][31], loc_reg[1]};
            end
            MUL_PZ:
            begin
                op_a = {pnz[31], pnz};
                op_b = {loc_reg[2][31], loc_reg[2]};
            end
            MUL_SQ:
            begin
                op_a = {1'b0, du_reg};
                op_b = {1'b0, du_reg};
            end
            MUL_SPH:
            begin
                op_a = {loc_reg[cmd.col][31], loc_reg[cmd.col]};
                op_b = {loc_reg[cmd.col][31], loc_reg[cmd.col]};
            end
            MUL_T1H:
            begin
                op_a = {1'b0, pcap_reg[47:16]};
                op_b = {1'b0, inv_in_reg};
            end
            MUL_T1L:
            begin
                op_a = {17'd0, pcap_reg[15:0]};
                op_b = {1'b0, inv_in_reg};
            end
            MUL_T2H:
            begin
                op_a = {1'b0, sph_reg[47:16]};
                op_b = {1'b0, inv_out_reg};
            end
            MUL_T2L:
            begin
                op_a = {17'd0, sph_reg[15:0]};
                op_b = {1'b0, inv_out_reg};
            end
            MUL_B1H:
            begin
                op_a = {16'd0, omk};
                op_b = {1'b0, t1_reg[47:16]};
            end
            MUL_B1L:
            begin
                op_a = {16'd0, omk};
                op_b = {17'd0, t1_reg[15:0]};
            end
            MUL_B2H:
            begin
                op_a = {16'd0, kc_reg};
                op_b = {1'b0, t2_reg[47:16]};
            end
            MUL_B2L:
            begin
                op_a = {16'd0, kc_reg};
                op_b = {17'd0, t2_reg[15:0]};
            end
            default:
            begin
                op_a = 33'sd0;
                op_b = 33'sd0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Shared rounding terms
    assign prod_ext = {{2{prod_reg[65]}}, prod_reg};
    assign sum_w    = acc_reg + prod_ext;
    assign rnd_w    = (sum_w + HALF_LSB) >>> 16;
    assign prnd_w   = (prod_ext + HALF_LSB) >>> 16;
    assign tsum_w   = acc_reg + prnd_w;
    assign dv_w     = rnd_w - {{36{poff[31]}}, poff};
    assign fr_w     = rnd_w - 68'(ONE_Q16);
    assign sqr_w    = prod_reg + 66'sd32768;

    // Apply the action that goes with last cycle's product
    always_comb
    begin
        acc_next  = acc_reg;
        du_next   = du_reg;
        psum_next = psum_reg;
        sph_next  = sph_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        f_next    = f_reg;
        fsat_next = fsat_reg;
        for (int i = 0; i < 3; i++)
        begin
            loc_next[i] = loc_reg[i];
        end
        case (act_reg)
            ACT_LOAD:    acc_next = prod_ext;
            ACT_ADD:     acc_next = sum_w;
            ACT_LOAD_HI: acc_next = prod_ext <<< 16;
            ACT_ADD_HI:  acc_next = acc_reg + (prod_ext <<< 16);
            ACT_ROW_END: loc_next[row_d_reg] = sat32(rnd_w);
            ACT_LOC_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    loc_next[i] = sat32(68'(pt_reg[i]) - 68'(centre_reg[i]));
                end
            end
            ACT_DIST:
            begin
                if (dv_w <= 68'sd0)
                begin
                    du_next = 32'd0;
                end
                else if (dv_w > 68'sh0_0000_0000_FFFF_FFFF)
                begin
                    du_next = 32'hFFFF_FFFF;
                end
                else
                begin
                    du_next = dv_w[31:0];
                end
            end
            ACT_SQ:      psum_next = psum_reg + PSUM_W'(sqr_w[63:16]);
            ACT_SPH:     sph_next = rnd_w[47:0];
            ACT_TERM1:   t1_next = (tsum_w > TERM_CAP) ? TERM_CAP[47:0] : tsum_w[47:0];
            ACT_TERM2:   t2_next = (tsum_w > TERM_CAP) ? TERM_CAP[47:0] : tsum_w[47:0];
            ACT_FINAL:
            begin
                if (fr_w > OUT_MAX)
                begin
                    f_next    = OUT_MAX[47:0];
                    fsat_next = 1'b1;
                end
                else
                begin
                    f_next    = fr_w[47:0];
                    fsat_next = 1'b0;
                end
            end
            default:     acc_next = acc_reg;
        endcase
    end

    // Action pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= ACT_NONE;
            row_d_reg <= 2'd0;
        end
        else
        begin
            act_reg   <= cmd.act;
            row_d_reg <= cmd.row;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        du_reg   <= du_next;
        sph_reg  <= sph_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        f_reg    <= f_next;
        fsat_reg <= fsat_next;
        for (int i = 0; i < 3; i++)
        begin
            loc_reg[i] <= loc_next[i];
        end
        if (item_xfer && (item_data.operation == OP_EVAL))
        begin
            psum_reg <= '0;
        end
        else
        begin
            psum_reg <= psum_next;
        end
        // Cap the plane sum and clip the blend weight one stage ahead
        pcap_reg <= (PSUM_W'(TERM_CAP[47:0]) < psum_reg) ? TERM_CAP[47:0] : psum_reg[47:0];
        kc_reg   <= (blend_reg > ONE_Q16) ? ONE_Q16 : blend_reg;
        if (cmd.publish)
        begin
            out_reg.potential <= f_reg;
            out_reg.saturated <= fsat_reg;
        end
    end

    assign result_data = out_reg;
endmodule

// ===== rtl/potential_particle_field_eval_unit.sv =====
// Top level of the potential-particle field evaluator.
`timescale 1ns / 1ps
// Usage:
//   item channel (valid/ready) takes load and evaluate items. Loads of the
//   plane table, a rotation row or the centre complete in the transfer cycle
//   and give no result. An evaluate item gives one result on the result
//   channel: the potential in signed Q32.16 and a saturation flag.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   to be written only while no point is in flight; the block does not
//   enforce this. In rotation mode a point passes through the rotation, the
//   plane loop, the norm and the weighted terms; in centre mode the centre
//   subtraction takes the place of the rotation. One multiplier is shared
//   by all products: nine for the rotation, four per plane (three for the
//   distance, then the square, with a gap state between for the plane table
//   read), three for the norm and eight for the weighted terms and the
//   blend. Items are taken one at a time.
//   The result sits in an output register; a new point is accepted while it
//   waits. When the sink stalls and a second result is ready, the block
//   holds that result until the first transfer completes.
//   Reset clears the configuration to its defaults, the rotation to the
//   identity and the centre to zero; plane entries hold nothing until loaded.
module potential_particle_field_eval_unit #(
    parameter int MAX_PLANES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ppfe_stream_if.sink          item,
    ppfe_stream_if.source        result,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import ppfe_pkg::*;

    localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    in_item_t   item_data;
    out_item_t  result_data;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [AW-1:0] plane_addr;
    logic       item_ready;
    logic       item_xfer;

    assign item_data      = item.payload;
    assign item.ready     = item_ready;
    assign item_xfer      = item.valid && item_ready;
    assign result.payload = result_data;

    ppfe_ctrl #(
        .MAX_PLANES (MAX_PLANES),
        .AW         (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_op      (item_data.operation),
        .item_ready   (item_ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd),
        .plane_addr   (plane_addr)
    );

    ppfe_datapath #(
        .MAX_PLANES (MAX_PLANES),
        .AW         (AW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_xfer   (item_xfer),
        .item_data   (item_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .plane_addr  (plane_addr),
        .status      (status),
        .result_data (result_data)
    );
endmodule
